FILE: rtl/core/c3lb_pkg.sv
// shared types and constants of the 3x3 convolution line buffer
package c3lb_pkg;

    localparam int PIX_W         = 8;
    localparam int CFG_W         = 11;
    localparam int COEF_W        = 16;
    localparam int KERNEL_N      = 3;
    localparam int COEF_ROW_W    = KERNEL_N * COEF_W;
    localparam int PROD_W        = PIX_W + 1 + COEF_W;
    localparam int RSUM_W        = PROD_W + 2;
    localparam int RES_W         = 28;
    localparam int IN_TDATA_W    = ((PIX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((RES_W + 7) / 8) * 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = COEF_ROW_W;
    localparam int MIN_SIZE      = 3;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int RST_FRAME_SIZE = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_COEF_TOP     = 3'd2,
        CFG_COEF_MID     = 3'd3,
        CFG_COEF_BOT     = 3'd4
    } t_cfg_idx;

    // one line store entry: pixel of this column two rows up and one row up
    typedef struct packed {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
    } t_col_pair;

endpackage

FILE: rtl/core/conv3x3_line_buffer_core.sv
// top level of the streaming 3x3 convolution line buffer
//
// usage
//   pixels of a frame enter in raster order on the s_axis channel, one 8-bit
//   pixel per beat. once the pixel's row and column index are both at least 2,
//   one beat leaves on m_axis: the 28-bit signed correlation of the 3x3
//   window ending at that pixel; tlast marks the last beat of the frame.
//   frame size and the nine coefficients are set through the write port
//   (index 0 width, 1 height, 2..4 coefficient rows top to bottom) while idle.
// throughput
//   one pixel per cycle while m_axis keeps up. the line store is read when the
//   pixel is taken and written back when it leaves stage 1, so one memory port
//   pair sets the rate.
// reset
//   counters, window and pipeline valids clear; size registers go to
//   1024x1024 and coefficients to zero. the line store is not cleared.
// receiver stall
//   the output register holds; earlier stages keep filling until the first
//   full stage, and pixels that make no result never block.
module conv3x3_line_buffer_core
    import c3lb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // config write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // pixel input
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] pixel
    // result output
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // [27:0] filtered_value, rest zero
    output logic                    m_axis_tlast    // frame_done
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    // compare widths wide enough for the config value and the size limit
    localparam int WCMP_W = (CFG_W > CW + 1) ? CFG_W : CW + 1;
    localparam int HCMP_W = (CFG_W > RW + 1) ? CFG_W : RW + 1;

    // ---------------- configuration registers
    logic [CFG_W-1:0]      r_frame_width;
    logic [CFG_W-1:0]      r_frame_height;
    logic [COEF_ROW_W-1:0] r_coef [KERNEL_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(RST_FRAME_SIZE);
            r_frame_height <= CFG_W'(RST_FRAME_SIZE);
            for (int m = 0; m < KERNEL_N; m++) begin
                r_coef[m] <= '0;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[CFG_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[CFG_W-1:0];
                CFG_COEF_TOP:     r_coef[0]      <= i_cfg_data[COEF_ROW_W-1:0];
                CFG_COEF_MID:     r_coef[1]      <= i_cfg_data[COEF_ROW_W-1:0];
                CFG_COEF_BOT:     r_coef[2]      <= i_cfg_data[COEF_ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- effective size, clamped into [3, max]
    logic [WCMP_W-1:0] fw_ext;
    logic [WCMP_W-1:0] last_col;
    logic [HCMP_W-1:0] fh_ext;
    logic [HCMP_W-1:0] last_row_idx;

    always_comb begin
        fw_ext = WCMP_W'(r_frame_width);
        fh_ext = HCMP_W'(r_frame_height);
        if (fw_ext < WCMP_W'(MIN_SIZE)) begin
            last_col = WCMP_W'(MIN_SIZE - 1);
        end else if (fw_ext > WCMP_W'(MAX_WIDTH)) begin
            last_col = WCMP_W'(MAX_WIDTH - 1);
        end else begin
            last_col = fw_ext - WCMP_W'(1);
        end
        if (fh_ext < HCMP_W'(MIN_SIZE)) begin
            last_row_idx = HCMP_W'(MIN_SIZE - 1);
        end else if (fh_ext > HCMP_W'(MAX_HEIGHT)) begin
            last_row_idx = HCMP_W'(MAX_HEIGHT - 1);
        end else begin
            last_row_idx = fh_ext - HCMP_W'(1);
        end
    end

    // ---------------- stage handshake chain
    logic accept;
    logic rdy_out, rdy3, rdy2, rdy1;
    logic r_v1, r_v2, r_v3, r_vo;
    logic r_prod1;

    assign rdy_out       = !r_vo || m_axis_tready;
    assign rdy3          = !r_v3 || rdy_out;
    assign rdy2          = !r_v2 || rdy3;
    // a pixel with no result leaves stage 1 without needing stage 2
    assign rdy1          = !r_v1 || !r_prod1 || rdy2;
    assign s_axis_tready = rdy1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ---------------- position counters, stepped on each accepted beat
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          row_end, last_row, produce, frame_end;

    always_comb begin
        row_end   = WCMP_W'(r_col) >= last_col;
        last_row  = HCMP_W'(r_row) >= last_row_idx;
        produce   = (WCMP_W'(r_col) >= WCMP_W'(2)) && (HCMP_W'(r_row) >= HCMP_W'(2));
        frame_end = row_end && last_row;
        n_col     = r_col;
        n_row     = r_row;
        if (accept) begin
            if (row_end) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- stage 1: line store read data arrives
    logic [PIX_W-1:0] r_pix1;
    logic [CW-1:0]    r_col1;
    logic             r_last1;
    logic             s1_leave;
    t_col_pair        ls_rd;
    t_col_pair        ls_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix1  <= s_axis_tdata[PIX_W-1:0];
            r_col1  <= r_col;
            r_prod1 <= produce;
            r_last1 <= frame_end;
        end
    end

    assign s1_leave     = r_v1 && rdy1;
    // the column shifts one row up: old newer becomes older, pixel becomes newer
    assign ls_wr.older  = ls_rd.newer;
    assign ls_wr.newer  = r_pix1;

    c3lb_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (ls_rd),
        .i_wr_en   (s1_leave),
        .i_wr_addr (r_col1),
        .i_wr_data (ls_wr)
    );

    // ---------------- sliding window, row 0 oldest, column 2 newest
    logic [PIX_W-1:0] r_win [KERNEL_N][KERNEL_N];
    logic [PIX_W-1:0] n_win [KERNEL_N][KERNEL_N];

    always_comb begin
        for (int m = 0; m < KERNEL_N; m++) begin
            n_win[m][0] = r_win[m][1];
            n_win[m][1] = r_win[m][2];
        end
        n_win[0][2] = ls_rd.older;
        n_win[1][2] = ls_rd.newer;
        n_win[2][2] = r_pix1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < KERNEL_N; m++) begin
                for (int n = 0; n < KERNEL_N; n++) begin
                    r_win[m][n] <= '0;
                end
            end
        end else if (s1_leave) begin
            r_win <= n_win;
        end
    end

    // ---------------- stage 2: nine products
    logic signed [PROD_W-1:0] r_prod [KERNEL_N][KERNEL_N];
    logic                     r_last2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1 && r_prod1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1 && r_prod1) begin
            r_last2 <= r_last1;
            for (int m = 0; m < KERNEL_N; m++) begin
                for (int n = 0; n < KERNEL_N; n++) begin
                    r_prod[m][n] <= $signed({1'b0, n_win[m][n]})
                                  * $signed(r_coef[m][n*COEF_W +: COEF_W]);
                end
            end
        end
    end

    // ---------------- stage 3: one sum per kernel row
    logic signed [RSUM_W-1:0] r_rsum [KERNEL_N];
    logic                     r_last3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_last3 <= r_last2;
            for (int m = 0; m < KERNEL_N; m++) begin
                r_rsum[m] <= RSUM_W'(r_prod[m][0]) + RSUM_W'(r_prod[m][1])
                           + RSUM_W'(r_prod[m][2]);
            end
        end
    end

    // ---------------- output register
    logic signed [RES_W-1:0] r_res;
    logic                    r_last_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (rdy_out) begin
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out && r_v3) begin
            r_last_o <= r_last3;
            r_res    <= RES_W'(r_rsum[0]) + RES_W'(r_rsum[1]) + RES_W'(r_rsum[2]);
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, r_res};
    assign m_axis_tlast  = r_last_o;

    // ---------------- assertions
    // read and write-back of the line store never hit the same column together
    a_no_rmw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s1_leave) |-> (r_col != r_col1))
        else $error("line store read and write-back collide");

    // column counter stays inside the line store
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WCMP_W'(r_col) <= WCMP_W'(MAX_WIDTH - 1)))
        else $error("column counter beyond line store depth");

    // with every stage full and the receiver stalled, no pixel is taken
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && !m_axis_tready && r_v3 && r_v2 && r_v1 && r_prod1) |-> !s_axis_tready)
        else $error("pixel taken while pipeline is full");

    // the newest window pixel only moves when a pixel leaves stage 1
    a_win_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!s1_leave) |=> $stable(r_win[2][2]))
        else $error("window changed without a pixel");

endmodule

FILE: rtl/core/c3lb_line_store.sv
// dual row line store: one synchronous memory, registered read, one write port
module c3lb_line_store
    import c3lb_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    output t_col_pair                    o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  t_col_pair                    i_wr_data
);

    t_col_pair r_mem [MAX_WIDTH];
    t_col_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: bench/conv3x3_line_buffer_core_tb.sv
// testbench of the 3x3 convolution line buffer core: random frames against a window tracker
module conv3x3_line_buffer_core_tb;
    import c3lb_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RST_CYCLES  = 11;
    localparam int MAX_GAP     = 16;
    localparam int LONG_HOLD   = 400;    // receiver hold-off, long enough to back up the input
    localparam int HOLD_EVERY  = 700;    // result beats between two hold-offs
    localparam int SETTLE      = 8;      // margin for trailing pixels to leave the pipeline
    localparam int STALL_LIMIT = 4000;   // cycles without any beat before giving up
    localparam int RAND_PIXELS = 1350;
    localparam int PRIME_WIDTH = 40;     // widest row any later frame reaches

    localparam logic [COEF_ROW_W-1:0] COEF_ALL_MIN = {KERNEL_N{16'h8000}};
    localparam logic [COEF_ROW_W-1:0] COEF_ALL_MAX = {KERNEL_N{16'h7fff}};

    typedef struct {
        logic signed [RES_W-1:0] value;
        logic                    done;
    } t_conv_out;

    // tracks frame position, line stores and window, and holds the sums still owed
    class window_sum_tracker;
        logic [CFG_W-1:0]      width_reg;
        logic [CFG_W-1:0]      height_reg;
        logic [COEF_ROW_W-1:0] coef_rows [KERNEL_N];
        logic [PIX_W-1:0]      older_line [DEF_MAX_WIDTH];
        logic [PIX_W-1:0]      newer_line [DEF_MAX_WIDTH];
        logic [PIX_W-1:0]      win [KERNEL_N][KERNEL_N];
        int unsigned           row_idx;
        int unsigned           col_idx;
        t_conv_out             pending_sums [$];
        int                    errors;

        function new();
            width_reg  = RST_FRAME_SIZE;
            height_reg = RST_FRAME_SIZE;
            row_idx    = 0;
            col_idx    = 0;
            errors     = 0;
            foreach (coef_rows[m]) coef_rows[m] = '0;
            foreach (win[m, n]) win[m][n] = '0;
            foreach (older_line[c]) begin
                older_line[c] = '0;
                newer_line[c] = '0;
            end
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg    = data[CFG_W-1:0];
                CFG_FRAME_HEIGHT: height_reg   = data[CFG_W-1:0];
                CFG_COEF_TOP:     coef_rows[0] = data;
                CFG_COEF_MID:     coef_rows[1] = data;
                CFG_COEF_BOT:     coef_rows[2] = data;
                default: ;
            endcase
        endfunction

        function int unsigned clamp_size(logic [CFG_W-1:0] raw, int unsigned limit);
            if (raw < MIN_SIZE)
                return MIN_SIZE;
            if (raw > limit)
                return limit;
            return raw;
        endfunction

        function void take_pixel(logic [PIX_W-1:0] pix);
            int unsigned      w, h;
            int               m, n;
            logic [PIX_W-1:0] top, mid;
            logic             row_end, last_row;
            longint           acc;
            t_conv_out        res;
            w        = clamp_size(width_reg, DEF_MAX_WIDTH);
            h        = clamp_size(height_reg, DEF_MAX_HEIGHT);
            // a counter already past a shrunken size counts as sitting on the last index
            row_end  = (col_idx >= w - 1);
            last_row = (row_idx >= h - 1);
            top = older_line[col_idx];
            mid = newer_line[col_idx];
            older_line[col_idx] = mid;
            newer_line[col_idx] = pix;
            for (m = 0; m < KERNEL_N; m++) begin
                win[m][0] = win[m][1];
                win[m][1] = win[m][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = pix;
            if (row_idx >= 2 && col_idx >= 2) begin
                acc = 0;
                for (m = 0; m < KERNEL_N; m++)
                    for (n = 0; n < KERNEL_N; n++)
                        acc += longint'(win[m][n]) *
                               longint'($signed(coef_rows[m][COEF_W*n +: COEF_W]));
                res.value = acc[RES_W-1:0];
                res.done  = row_end && last_row;
                pending_sums.push_back(res);
            end
            if (row_end) begin
                col_idx = 0;
                row_idx = last_row ? 0 : row_idx + 1;
            end else begin
                col_idx = col_idx + 1;
            end
        endfunction

        function void check_sum(logic [RES_W-1:0] value, logic done);
            t_conv_out want;
            if (pending_sums.size() == 0) begin
                $error("result beat with none owed: filtered_value %0d frame_done %0b",
                       $signed(value), done);
                errors++;
            end else begin
                want = pending_sums.pop_front();
                if (value !== want.value) begin
                    $error("filtered_value: expected %0d, actual %0d",
                           want.value, $signed(value));
                    errors++;
                end
                if (done !== want.done) begin
                    $error("frame_done: expected %0b, actual %0b", want.done, done);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] pixel
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [27:0] filtered_value, rest zero
    logic                   m_axis_tlast;         // frame_done

    window_sum_tracker tracker = new();
    bit                send_burst = 1'b0;   // sender runs without gaps while set

    conv3x3_line_buffer_core uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // one register write; the enable stays up when another write follows at once
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data,
                             input bit more);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        if (!more)
            i_cfg_we <= 1'b0;
    endtask

    // size writes carry random junk above the 11 register bits
    task automatic set_size(input int unsigned w, input int unsigned h, input bit more);
        logic [CFG_DATA_W-1:0] wd, hd;
        wd = CFG_DATA_W'({$urandom, $urandom});
        hd = CFG_DATA_W'({$urandom, $urandom});
        wd[CFG_W-1:0] = CFG_W'(w);
        hd[CFG_W-1:0] = CFG_W'(h);
        cfg_write(CFG_FRAME_WIDTH, wd, 1'b1);
        cfg_write(CFG_FRAME_HEIGHT, hd, more);
    endtask

    task automatic set_coefs(input logic [COEF_ROW_W-1:0] top, input logic [COEF_ROW_W-1:0] mid,
                             input logic [COEF_ROW_W-1:0] bot);
        cfg_write(CFG_COEF_TOP, top, 1'b1);
        cfg_write(CFG_COEF_MID, mid, 1'b1);
        cfg_write(CFG_COEF_BOT, bot, 1'b0);
    endtask

    // random kernel row, with the tap extremes and zero mixed in
    function automatic logic [COEF_ROW_W-1:0] rand_coef_row();
        logic [COEF_ROW_W-1:0] row;
        int                    n;
        for (n = 0; n < KERNEL_N; n++) begin
            case ($urandom_range(0, 7))
                0:       row[COEF_W*n +: COEF_W] = 16'h8000;
                1:       row[COEF_W*n +: COEF_W] = 16'h7fff;
                2:       row[COEF_W*n +: COEF_W] = '0;
                default: row[COEF_W*n +: COEF_W] = COEF_W'($urandom);
            endcase
        end
        return row;
    endfunction

    // offer one pixel beat after a random gap, or at once in a burst; called and returns at a falling edge
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        if ($urandom_range(0, 47) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(pix);
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_pixel(pix);
        @(negedge i_clk);
    endtask

    // all owed sums in, then let trailing pixels that make no sum leave the pipeline
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_sums.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // result side: random ready gaps, bursts of constant ready, and a long
    // hold-off now and then so the pipeline backs up into the pixel input
    initial begin : result_sink
        int gap;
        int taken;
        bit burst;
        taken = 0;
        burst = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 47) == 0)
                burst = !burst;
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (taken % HOLD_EVERY == HOLD_EVERY / 2)
                gap = LONG_HOLD;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            tracker.check_sum(m_axis_tdata[RES_W-1:0], m_axis_tlast);
            taken++;
            @(negedge i_clk);
        end
    end

    // watchdog: any beat or register write counts as progress
    initial begin : stall_watch
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("conv3x3_line_buffer_core_tb: errors");
        $finish;
    end

    initial begin : stimulus
        int               i, w, h, nw, nh, fed, in_frame, cut;
        bit               extremes;
        logic [PIX_W-1:0] pix;

        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // smallest frame through the low clamp: all-max pixels on all-min taps,
        // the most negative sum there is
        set_size(0, 0, 1'b1);
        set_coefs(COEF_ALL_MIN, COEF_ALL_MIN, COEF_ALL_MIN);
        repeat (9) send_pixel(8'hff);
        wait_idle();

        // height past the top of the range, then resized inside row 2: width 4 -> 3
        // with the column counter already beyond the new end, height down to 3 so
        // the very next pixel closes the frame
        set_size(4, 2047, 1'b1);
        set_coefs(COEF_ALL_MAX, COEF_ALL_MAX, COEF_ALL_MAX);
        for (i = 0; i < 11; i++)
            send_pixel((i % 3 == 0) ? 8'hff : 8'h00);
        wait_idle();
        set_size(3, 3, 1'b0);
        send_pixel(8'hff);
        wait_idle();

        // one frame at the widest later width so every column that later frames
        // reach holds written data; after this, widening a frame part way through is safe
        set_size(PRIME_WIDTH, 3, 1'b1);
        set_coefs(rand_coef_row(), rand_coef_row(), rand_coef_row());
        repeat (3 * PRIME_WIDTH) send_pixel(PIX_W'($urandom));
        wait_idle();

        // random small frames, some resized while under way
        fed = 0;
        while (fed < RAND_PIXELS) begin
            w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2)
                                             : $urandom_range(3, PRIME_WIDTH);
            h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            set_size(w, h, 1'b1);
            set_coefs(rand_coef_row(), rand_coef_row(), rand_coef_row());
            extremes = ($urandom_range(0, 7) == 0);
            cut      = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 120) : 0;
            in_frame = 0;
            do begin
                pix = extremes ? ($urandom_range(0, 1) ? 8'hff : 8'h00) : PIX_W'($urandom);
                send_pixel(pix);
                fed++;
                in_frame++;
                if (in_frame == cut) begin
                    wait_idle();
                    nw = $urandom_range(3, PRIME_WIDTH);
                    nh = $urandom_range(0, 8);
                    set_size(nw, nh, 1'b0);
                end
            end while (tracker.row_idx != 0 || tracker.col_idx != 0);
            wait_idle();
        end

        repeat (SETTLE) @(negedge i_clk);
        if (tracker.errors == 0)
            $display("conv3x3_line_buffer_core_tb: clean");
        else
            $display("conv3x3_line_buffer_core_tb: errors");
        $finish;
    end

endmodule
